/* hw/rtl/tli_pkg.sv */
package tli_pkg;

    localparam int unsigned TableDepthDefault = 256;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_SPARE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] point_key;
        logic signed [31:0] point_value;
        logic signed [31:0] query_position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interpolated;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_RD_FIRST,
        BS_RD_LAST,
        BS_CHECK_END,
        BS_SEARCH_RD,
        BS_SEARCH_CMP,
        BS_DIFF,
        BS_MUL_LO,
        BS_MUL_HI,
        BS_DIV,
        BS_SUM,
        BS_DONE
    } t_bstate;

endpackage

/* hw/rtl/tli_front.sv */
// front part: takes transactions and queues them for the back part
module tli_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  tli_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output tli_pkg::t_in_item o_item
);

    tli_pkg::t_in_item r_slot [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

/* hw/rtl/tli_div.sv */
// restoring divider, one quotient bit a cycle, 66-bit dividend by 34-bit divisor
module tli_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_done,
    output logic [40:0] o_quo
);

    logic [65:0] r_num;
    logic [34:0] r_rem;
    logic [65:0] r_quo;
    logic [33:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] w_sh;
    logic        w_ge;
    logic        w_sat;

    assign w_sh  = {r_rem[33:0], r_num[65]};
    assign w_ge  = (w_sh >= {1'b0, r_den});
    assign w_sat = |r_quo[65:40];
    assign o_done = r_done;
    assign o_quo  = w_sat ? {1'b1, 40'd0}
                  : (r_quo[40:0] > {1'b1, 40'd0} ? {1'b1, 40'd0} : r_quo[40:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd66;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= 35'd0;
                r_quo  <= 66'd0;
            end else if (r_busy) begin
                r_num <= {r_num[64:0], 1'b0};
                r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
                r_quo <= {r_quo[64:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/tli_back.sv */
// back part: table, binary search and interpolation sequencer
module tli_back #(
    parameter int unsigned TableDepth = tli_pkg::TableDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_take,
    input  tli_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    input  logic               i_res_pop,
    output tli_pkg::t_out_item o_res
);

    localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int unsigned CW = $clog2(TableDepth + 1);

    logic signed [31:0] r_key_mem [TableDepth];
    logic signed [31:0] r_val_mem [TableDepth];
    logic signed [31:0] r_key_rd;
    logic signed [31:0] r_val_rd;
    logic [AW-1:0]      w_rd_addr;
    logic [CW-1:0]      r_count;

    tli_pkg::t_bstate   r_state;
    tli_pkg::t_bstate   n_state;
    logic signed [31:0] r_q;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic signed [31:0] r_xl;
    logic signed [31:0] r_yl;
    logic signed [31:0] r_xh;
    logic signed [31:0] r_yh;
    logic               r_neg;
    logic [33:0]        r_mdq;
    logic [33:0]        r_mdy;
    logic [33:0]        r_mdx;
    logic [65:0]        r_prod;
    logic signed [31:0] r_out_val;
    logic [1:0]         r_out_st;
    logic               r_out_valid;
    logic               r_div_start;
    logic [CW-1:0]      w_mid;
    logic               w_div_done;
    logic [40:0]        w_quo;
    logic signed [33:0] w_dq;
    logic signed [33:0] w_dy;
    logic signed [33:0] w_dx;
    logic signed [42:0] w_sum;
    logic               w_is_query;
    logic               w_short_ok;
    logic [16:0]        w_mul_b;
    logic [50:0]        w_pp;

    assign w_mid = CW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_dq  = 34'(r_q) - 34'(r_xl);
    assign w_dy  = 34'(r_yh) - 34'(r_yl);
    assign w_dx  = 34'(r_xh) - 34'(r_xl);
    assign w_sum = r_neg ? (43'(r_yl) - $signed({2'b0, w_quo}))
                         : (43'(r_yl) + $signed({2'b0, w_quo}));
    assign w_is_query = (tli_pkg::t_cmd'(i_item.command) == tli_pkg::CMD_QUERY);
    assign w_short_ok = (r_count >= CW'(2));

    // product in two halves of the dy magnitude
    assign w_mul_b = (r_state == tli_pkg::BS_MUL_HI) ? r_mdy[33:17] : r_mdy[16:0];
    assign w_pp    = 51'(r_mdq) * 51'(w_mul_b);

    assign o_res_valid = r_out_valid;
    assign o_res.interpolated = r_out_val;
    assign o_res.status       = r_out_st;

    tli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_prod),
        .i_den   (r_mdx),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        r_key_rd <= r_key_mem[w_rd_addr];
        r_val_rd <= r_val_mem[w_rd_addr];
        if (r_state == tli_pkg::BS_IDLE && i_valid && !r_out_valid &&
            tli_pkg::t_cmd'(i_item.command) == tli_pkg::CMD_APPEND &&
            r_count < CW'(TableDepth)) begin
            r_key_mem[r_count[AW-1:0]] <= i_item.point_key;
            r_val_mem[r_count[AW-1:0]] <= i_item.point_value;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tli_pkg::BS_IDLE: begin
                if (i_valid && !r_out_valid) begin
                    n_state = (w_is_query && w_short_ok) ? tli_pkg::BS_RD_FIRST
                                                         : tli_pkg::BS_IDLE;
                end
            end
            tli_pkg::BS_RD_FIRST:   n_state = tli_pkg::BS_RD_LAST;
            tli_pkg::BS_RD_LAST:    n_state = tli_pkg::BS_CHECK_END;
            tli_pkg::BS_CHECK_END: begin
                if (r_q <= r_xl || r_q >= r_xh) begin
                    n_state = tli_pkg::BS_DONE;
                end else if (r_hi - r_lo > CW'(1)) begin
                    n_state = tli_pkg::BS_SEARCH_RD;
                end else begin
                    n_state = tli_pkg::BS_DIFF;
                end
            end
            tli_pkg::BS_SEARCH_RD:  n_state = tli_pkg::BS_SEARCH_CMP;
            tli_pkg::BS_SEARCH_CMP: begin
                n_state = tli_pkg::BS_SEARCH_RD;
                if (r_key_rd <= r_q) begin
                    if (r_hi - w_mid <= CW'(1)) n_state = tli_pkg::BS_DIFF;
                end else begin
                    if (w_mid - r_lo <= CW'(1)) n_state = tli_pkg::BS_DIFF;
                end
            end
            tli_pkg::BS_DIFF: begin
                n_state = (w_dx == 34'sd0) ? tli_pkg::BS_DONE : tli_pkg::BS_MUL_LO;
            end
            tli_pkg::BS_MUL_LO:     n_state = tli_pkg::BS_MUL_HI;
            tli_pkg::BS_MUL_HI:     n_state = tli_pkg::BS_DIV;
            tli_pkg::BS_DIV:        n_state = w_div_done ? tli_pkg::BS_SUM : tli_pkg::BS_DIV;
            tli_pkg::BS_SUM:        n_state = tli_pkg::BS_IDLE;
            tli_pkg::BS_DONE:       n_state = tli_pkg::BS_IDLE;
            default:                n_state = tli_pkg::BS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_take    = 1'b0;
        w_rd_addr = '0;
        unique case (r_state)
            tli_pkg::BS_IDLE: begin
                o_take    = i_valid && !r_out_valid;
                w_rd_addr = '0;
            end
            tli_pkg::BS_RD_FIRST:  w_rd_addr = r_hi[AW-1:0];
            tli_pkg::BS_SEARCH_RD: w_rd_addr = w_mid[AW-1:0];
            default:               w_rd_addr = r_hi[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_div_start <= (r_state == tli_pkg::BS_MUL_HI);
        unique case (r_state)
            tli_pkg::BS_IDLE: begin
                r_q  <= i_item.query_position;
                r_lo <= '0;
                r_hi <= r_count - CW'(1);
            end
            tli_pkg::BS_RD_FIRST: begin
                // first entry now on read port
                r_xl <= r_key_rd;
                r_yl <= r_val_rd;
            end
            tli_pkg::BS_RD_LAST: begin
                // read port holds the last entry
                r_xh <= r_key_rd;
                r_yh <= r_val_rd;
            end
            tli_pkg::BS_SEARCH_CMP: begin
                // the probed entry becomes the new lower or upper bracket
                if (r_key_rd <= r_q) begin
                    r_lo <= w_mid;
                    r_xl <= r_key_rd;
                    r_yl <= r_val_rd;
                end else begin
                    r_hi <= w_mid;
                    r_xh <= r_key_rd;
                    r_yh <= r_val_rd;
                end
            end
            tli_pkg::BS_DIFF: begin
                r_mdq <= w_dq[33] ? 34'(-w_dq) : 34'(w_dq);
                r_mdy <= w_dy[33] ? 34'(-w_dy) : 34'(w_dy);
                r_mdx <= w_dx[33] ? 34'(-w_dx) : 34'(w_dx);
                r_neg <= ((w_dq[33] ^ w_dy[33]) ^ w_dx[33]) &&
                         w_dq != 34'sd0 && w_dy != 34'sd0;
            end
            tli_pkg::BS_MUL_LO: begin
                r_prod <= 66'(w_pp);
            end
            tli_pkg::BS_MUL_HI: begin
                r_prod <= r_prod + {w_pp[48:0], 17'd0};
            end
            default: begin
            end
        endcase
    end

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tli_pkg::BS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_res_pop) r_out_valid <= 1'b0;
            unique case (r_state)
                tli_pkg::BS_IDLE: begin
                    if (i_valid && !r_out_valid) begin
                        r_out_val <= '0;
                        r_out_valid <= !(w_is_query && w_short_ok);
                        unique case (tli_pkg::t_cmd'(i_item.command))
                            tli_pkg::CMD_CLEAR: begin
                                r_count  <= '0;
                                r_out_st <= tli_pkg::ST_OK;
                            end
                            tli_pkg::CMD_APPEND: begin
                                if (r_count < CW'(TableDepth)) begin
                                    r_count  <= r_count + CW'(1);
                                    r_out_st <= tli_pkg::ST_OK;
                                end else begin
                                    r_out_st <= tli_pkg::ST_FULL;
                                end
                            end
                            tli_pkg::CMD_QUERY: begin
                                r_out_st <= w_short_ok ? tli_pkg::ST_OK : tli_pkg::ST_FEW;
                            end
                            default: r_out_st <= tli_pkg::ST_OK;
                        endcase
                    end
                end
                tli_pkg::BS_CHECK_END: begin
                    if (r_q <= r_xl) begin
                        r_out_val   <= r_yl;
                        r_out_valid <= 1'b1;
                    end else if (r_q >= r_xh) begin
                        r_out_val   <= r_yh;
                        r_out_valid <= 1'b1;
                    end
                end
                tli_pkg::BS_DIFF: begin
                    if (w_dx == 34'sd0) begin
                        r_out_val   <= r_yl;
                        r_out_valid <= 1'b1;
                    end
                end
                tli_pkg::BS_SUM: begin
                    r_out_valid <= 1'b1;
                    if (w_sum > 43'sd2147483647)       r_out_val <= 32'sh7fffffff;
                    else if (w_sum < -43'sd2147483648) r_out_val <= 32'sh80000000;
                    else                               r_out_val <= w_sum[31:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/table_linear_interpolator_core.sv */
// piecewise linear interpolation over a breakpoint table
// input queue side: push / full carry a command transaction (clear, append, query)
// result queue side: empty low shows the oldest result, pop takes it
// every transaction gives exactly one result
// a transaction is registered in the front queue, and the back takes it from there
// clear and append set the result on the edge on which the back takes them
// a query first reads the first and last entries and stops there when the
// position lies at or beyond an end key; otherwise a binary search over the table
// memory follows, each halving an address then a registered read, then the
// differences and a split product, the bit-serial divide with its start and done,
// and the saturating sum
// the back takes the next transaction only once the result register is free,
// in the cycle after the result is popped, so transactions run one at a time
// a two-entry queue parts the front from the back, so pushes keep landing
// while the back is busy; when the receiver stalls the back waits and the front fills
// reset empties both queues and sets the point count to zero
// table entries are undefined until appended; a query uses only entries below the point count
module table_linear_interpolator_core #(
    parameter int unsigned TableDepth = tli_pkg::TableDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tli_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output tli_pkg::t_out_item o_item
);

    logic              w_valid;
    logic              w_take;
    logic              w_res_valid;
    tli_pkg::t_in_item w_item;

    // front: command queue
    tli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (w_valid),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    // back: table, search and arithmetic
    tli_back #(.TableDepth(TableDepth)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .o_take      (w_take),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_pop   (pop),
        .o_res       (o_item)
    );

    assign empty = !w_res_valid;

endmodule

/* hw/rtl/tli_checker.sv */
module tli_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input tli_pkg::t_out_item o_item
);

    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_item.status != tli_pkg::ST_SPARE)
        else $error("unused status code");

    a_zero_on_error : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_item.status != tli_pkg::ST_OK |-> o_item.interpolated == 32'sd0)
        else $error("nonzero value with error status");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_item))
        else $error("result changed while stalled");

endmodule

bind table_linear_interpolator_core tli_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);
